// ===== rtl/core/sliding_window_percentile_top_defines.svh =====
// Assertion macros used by the checker file of this block.
`ifndef SLIDING_WINDOW_PERCENTILE_TOP_DEFINES_SVH
`define SLIDING_WINDOW_PERCENTILE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Checked also while reset is high.
`define SWP_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/swp_pkg.sv =====
`default_nettype none

package swp_pkg;

   localparam int SAMPLE_W   = 32;
   localparam int FRAC_W     = 17;
   localparam int FILL_OUT_W = 9;
   localparam int FRAC_BITS  = 16;
   localparam int HALF_Q16   = 32768;

   localparam logic KIND_RECORD = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_CLAMP,
      ST_SCAN,
      ST_DECIDE,
      ST_RESULT
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/swp_if.sv =====
`default_nettype none

interface swp_req_if;
   import swp_pkg::*;

   logic                valid;
   logic                ready;
   logic                kind;
   logic [SAMPLE_W-1:0] sample_us;
   logic [FRAC_W-1:0]   fraction_q16;

   modport source (output valid, kind, sample_us, fraction_q16, input ready);
   modport sink (input valid, kind, sample_us, fraction_q16, output ready);
endinterface

interface swp_rsp_if;
   import swp_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [SAMPLE_W-1:0]   percentile_value;
   logic [FILL_OUT_W-1:0] window_fill;

   modport source (output valid, percentile_value, window_fill, input ready);
   modport sink (input valid, percentile_value, window_fill, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/swp_ram.sv =====
`default_nettype none

module swp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/sliding_window_percentile_top.sv =====
// Latency percentile over a sliding window of the last WINDOW_DEPTH samples.
// The request channel carries one word per item: a record word (kind 0)
// stores sample_us in the ring and gives no response; a query word (kind 1)
// asks for the sample of rank round(fraction_q16 * (fill - 1)), capped at
// fill - 1, among the samples held, smallest first, and gives one response
// word with that value and the current fill. An empty window answers 0
// with fill 0. Records may arrive on every cycle while no query runs.
// A query runs a bitwise radix selection: one pass over the stored samples
// per result bit, one sample read from the sample memory per cycle through
// its single read port. An empty window skips the passes.
// While a query is in progress the request channel is not ready.
// The response sits in an output register; when the receiver stalls it holds
// there, and record words are still taken meanwhile.
// Synchronous reset empties the window, resets the write pointer and drops
// any pending response. Stored sample values are not cleared.
`default_nettype none

module sliding_window_percentile_top #(
   parameter int WINDOW_DEPTH = 256
) (
   input wire logic clock,
   input wire logic reset,
   swp_req_if.sink  req_chan,
   swp_rsp_if.source rsp_chan
);
   import swp_pkg::*;

   localparam int AW = $clog2(WINDOW_DEPTH);
   localparam int CW = $clog2(WINDOW_DEPTH + 1);
   localparam int PW = FRAC_W + CW;

   state_type state_ff, state_in;

   logic [AW-1:0]         wp_ff, wp_in;
   logic [CW-1:0]         fill_ff, fill_in;
   logic [FRAC_W-1:0]     frac_ff, frac_in;
   logic [PW-1:0]         prod_ff, prod_in;
   logic [CW-1:0]         rank_ff, rank_in;
   logic [SAMPLE_W-1:0]   prefix_ff, prefix_in;
   logic [SAMPLE_W-1:0]   mask_ff, mask_in;
   logic [SAMPLE_W-1:0]   bitsel_ff, bitsel_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [CW-1:0]         addr_ff, addr_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic                  out_vld_ff, out_vld_in;
   logic [SAMPLE_W-1:0]   out_value_ff, out_value_in;
   logic [FILL_OUT_W-1:0] out_fill_ff, out_fill_in;

   logic                   req_acc;
   logic                   wr_en;
   logic                   issue;
   logic                   hit;
   logic [SAMPLE_W-1:0]    rd_data;
   logic [CW-1:0]          fill_m1;
   logic [PW:0]            rank_full;
   logic [CW+FILL_OUT_W-1:0] fill_ext;

   assign req_acc  = req_chan.valid && req_chan.ready;
   assign wr_en    = req_acc && (req_chan.kind == KIND_RECORD);
   assign issue    = (state_ff == ST_SCAN) && (addr_ff != fill_ff);
   assign fill_m1  = fill_ff - 1'b1;
   assign rank_full = ((PW + 1)'(prod_ff) + (PW + 1)'(HALF_Q16)) >> FRAC_BITS;
   assign fill_ext = {{FILL_OUT_W{1'b0}}, fill_ff};

   // A sample counts when it matches the decided upper bits and has a zero
   // in the bit under decision.
   assign hit = rd_vld_ff && (((rd_data ^ prefix_ff) & mask_ff) == '0)
                && ((rd_data & bitsel_ff) == '0);

   assign req_chan.ready            = (state_ff == ST_IDLE);
   assign rsp_chan.valid            = out_vld_ff;
   assign rsp_chan.percentile_value = out_value_ff;
   assign rsp_chan.window_fill      = out_fill_ff;

   swp_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (req_chan.sample_us),
      .rd_en   (issue),
      .rd_addr (addr_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      frac_in      = frac_ff;
      prod_in      = prod_ff;
      rank_in      = rank_ff;
      prefix_in    = prefix_ff;
      mask_in      = mask_ff;
      bitsel_in    = bitsel_ff;
      cnt_in       = cnt_ff;
      addr_in      = addr_ff;
      rd_vld_in    = issue;
      out_vld_in   = out_vld_ff && !rsp_chan.ready;
      out_value_in = out_value_ff;
      out_fill_in  = out_fill_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_chan.kind == KIND_RECORD) begin
                  wp_in = (wp_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
                  if (fill_ff != CW'(WINDOW_DEPTH)) begin
                     fill_in = fill_ff + 1'b1;
                  end
               end else begin
                  frac_in   = req_chan.fraction_q16;
                  prefix_in = '0;
                  mask_in   = '0;
                  bitsel_in = {1'b1, {(SAMPLE_W - 1){1'b0}}};
                  cnt_in    = '0;
                  addr_in   = '0;
                  state_in  = (fill_ff == '0) ? ST_RESULT : ST_MUL;
               end
            end
         end
         ST_MUL: begin
            prod_in  = PW'(frac_ff) * PW'(fill_m1);
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            rank_in  = (rank_full > (PW + 1)'(fill_m1)) ? fill_m1 : rank_full[CW-1:0];
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (issue) begin
               addr_in = addr_ff + 1'b1;
            end
            if (hit) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (!issue && !rd_vld_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (rank_ff >= cnt_ff) begin
               prefix_in = prefix_ff | bitsel_ff;
               rank_in   = rank_ff - cnt_ff;
            end
            mask_in   = mask_ff | bitsel_ff;
            bitsel_in = bitsel_ff >> 1;
            cnt_in    = '0;
            addr_in   = '0;
            state_in  = bitsel_ff[0] ? ST_RESULT : ST_SCAN;
         end
         ST_RESULT: begin
            if (!out_vld_ff || rsp_chan.ready) begin
               out_vld_in   = 1'b1;
               out_value_in = prefix_ff;
               out_fill_in  = fill_ext[FILL_OUT_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         wp_ff      <= '0;
         fill_ff    <= '0;
         rd_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wp_ff      <= wp_in;
         fill_ff    <= fill_in;
         rd_vld_ff  <= rd_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      frac_ff      <= frac_in;
      prod_ff      <= prod_in;
      rank_ff      <= rank_in;
      prefix_ff    <= prefix_in;
      mask_ff      <= mask_in;
      bitsel_ff    <= bitsel_in;
      cnt_ff       <= cnt_in;
      addr_ff      <= addr_in;
      out_value_ff <= out_value_in;
      out_fill_ff  <= out_fill_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/swp_checker.sv =====
`default_nettype none
`include "sliding_window_percentile_top_defines.svh"

module swp_protocol_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_kind,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_value,
   input wire logic [8:0]  rsp_fill
);
   import swp_pkg::*;

   logic req_query;
   logic req_record;

   assign req_query  = req_valid && req_ready && (req_kind == KIND_QUERY);
   assign req_record = req_valid && req_ready && (req_kind == KIND_RECORD);

   // A stalled response word must hold its contents.
   `SWP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value) && $stable(rsp_fill), "response word changed while stalled")
   // A query keeps the request side busy for at least the next cycle.
   `SWP_ASSERT_NEXT(a_query_busy, clock, reset, req_query, !req_ready, "request ready right after a query")
   // A record never produces a response word.
   `SWP_ASSERT_NEXT(a_record_silent, clock, reset, req_record && !rsp_valid, !rsp_valid, "response after a record")
   // Reset drops any pending response.
   `SWP_ASSERT_ALWAYS_NEXT(a_reset_clear, clock, reset, !rsp_valid, "response valid after reset")

endmodule

bind sliding_window_percentile_top swp_protocol_checker u_swp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_kind  (req_chan.kind),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_value (rsp_chan.percentile_value),
   .rsp_fill  (rsp_chan.window_fill)
);

`default_nettype wire

// ===== tb/swp_checker.sv =====
`default_nettype none

module swp_checker #(
   parameter int WINDOW_DEPTH = 256
) (
   input wire logic clock,
   input wire logic reset,
   swp_req_if       req_mon,
   swp_rsp_if       rsp_mon,
   output int       error_count,
   output int       outstanding
);
   import swp_pkg::*;

   typedef struct packed {
      logic [SAMPLE_W-1:0]   value;
      logic [FILL_OUT_W-1:0] fill;
   } percentile_word_type;

   logic [SAMPLE_W-1:0] window_samples [WINDOW_DEPTH];
   int unsigned         next_slot;
   int unsigned         held;
   percentile_word_type percentile_q[$];
   percentile_word_type oldest;

   // Returns the value of rank k, smallest first, among the first n held samples.
   function automatic logic [SAMPLE_W-1:0] sample_of_rank(int unsigned n, int unsigned k);
      logic [SAMPLE_W-1:0] v;
      int unsigned         below;
      int unsigned         upto;
      for (int unsigned i = 0; i < n; i++) begin
         v = window_samples[i];
         below = 0;
         upto = 0;
         for (int unsigned j = 0; j < n; j++) begin
            if (window_samples[j] < v) below++;
            if (window_samples[j] <= v) upto++;
         end
         if (below <= k && k < upto) return v;
      end
      return '0;
   endfunction

   function automatic percentile_word_type predict_percentile(logic [FRAC_W-1:0] fraction);
      percentile_word_type w;
      longint unsigned     rank;
      w.value = '0;
      w.fill = FILL_OUT_W'(held);
      if (held > 0) begin
         rank = fraction;
         rank = (rank * (held - 1) + HALF_Q16) >> FRAC_BITS;
         if (rank > held - 1) rank = held - 1;
         w.value = sample_of_rank(held, int'(rank));
      end
      return w;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         next_slot = 0;
         held = 0;
         percentile_q.delete();
         error_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (percentile_q.size() == 0) begin
               $display("%0t: unexpected word: expected none, actual value %0d fill %0d",
                        $time, rsp_mon.percentile_value, rsp_mon.window_fill);
               error_count++;
            end else begin
               oldest = percentile_q.pop_front();
               if (rsp_mon.percentile_value !== oldest.value) begin
                  $display("%0t: percentile_value mismatch: expected %0d, actual %0d",
                           $time, oldest.value, rsp_mon.percentile_value);
                  error_count++;
               end
               if (rsp_mon.window_fill !== oldest.fill) begin
                  $display("%0t: window_fill mismatch: expected %0d, actual %0d",
                           $time, oldest.fill, rsp_mon.window_fill);
                  error_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.kind == KIND_RECORD) begin
               window_samples[next_slot] = req_mon.sample_us;
               next_slot = (next_slot + 1) % WINDOW_DEPTH;
               if (held < WINDOW_DEPTH) held++;
            end else begin
               percentile_q = {percentile_q, predict_percentile(req_mon.fraction_q16)};
            end
         end
      end
      outstanding = percentile_q.size();
   end

endmodule

`default_nettype wire

// ===== tb/sliding_window_percentile_top_tb.sv =====
`default_nettype none

module sliding_window_percentile_top_tb;
   import swp_pkg::*;

   localparam int WINDOW_DEPTH   = 256;
   localparam int RANDOM_ITEMS   = 530;
   localparam int WATCHDOG_LIMIT = 50000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int error_count;
   int outstanding;
   int records_sent = 0;
   int idle_cycles = 0;
   int req_calm = 0;
   int rsp_calm = 0;
   int query_pct;
   int rsp_gap;
   logic [SAMPLE_W-1:0] sample;
   logic [FRAC_W-1:0]   fraction;

   swp_req_if req_chan ();
   swp_rsp_if rsp_chan ();

   sliding_window_percentile_top #(
      .WINDOW_DEPTH(WINDOW_DEPTH)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   swp_checker #(
      .WINDOW_DEPTH(WINDOW_DEPTH)
   ) checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .error_count(error_count),
      .outstanding(outstanding)
   );

   always #5 clock = ~clock;

   function automatic int next_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) calm = $urandom_range(8, 40);
      return $urandom_range(0, 16);
   endfunction

   task automatic send_word(input logic kind, input logic [SAMPLE_W-1:0] value,
                            input logic [FRAC_W-1:0] frac);
      int gap;
      gap = next_gap(req_calm);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.kind <= kind;
      req_chan.sample_us <= value;
      req_chan.fraction_q16 <= frac;
      req_chan.valid <= 1'b1;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      @(negedge clock);
      if (kind == KIND_RECORD) records_sent++;
   endtask

   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      rsp_chan.ready <= 1'b0;
      @(negedge clock);
      forever begin
         rsp_gap = next_gap(rsp_calm);
         if (rsp_gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (rsp_gap) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         @(negedge clock);
      end
   end

   initial begin
      req_chan.valid <= 1'b0;
      req_chan.kind <= KIND_RECORD;
      req_chan.sample_us <= '0;
      req_chan.fraction_q16 <= '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // An empty window answers zero.
      send_word(KIND_QUERY, '0, 17'd0);
      send_word(KIND_QUERY, '0, 17'd65536);
      send_word(KIND_RECORD, 32'd0, '0);
      send_word(KIND_QUERY, '0, 17'd32768);
      send_word(KIND_RECORD, 32'hFFFF_FFFF, '0);
      send_word(KIND_RECORD, 32'd5, '0);
      send_word(KIND_RECORD, 32'd5, '0);
      send_word(KIND_QUERY, '0, 17'd0);
      send_word(KIND_QUERY, '0, 17'd1);
      send_word(KIND_QUERY, '0, 17'd65536);
      send_word(KIND_QUERY, '0, 17'h1_FFFF);
      send_word(KIND_QUERY, '0, 17'd32768);
      send_word(KIND_QUERY, '0, 17'd21845);
      send_word(KIND_RECORD, 32'h8000_0000, '0);
      send_word(KIND_RECORD, 32'd1, '0);
      send_word(KIND_RECORD, 32'hFFFF_FFFF, '0);
      send_word(KIND_QUERY, '0, 17'd98304);
      send_word(KIND_QUERY, '0, 17'd16384);
      send_word(KIND_QUERY, '0, 17'd49152);
      wait_for_results();

      // Queries are dense while the window is short and sparse after that,
      // since each one then scans every held sample many times.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 180 || i == 360) wait_for_results();
         if (records_sent < 48) query_pct = 25;
         else if (records_sent < WINDOW_DEPTH) query_pct = 5;
         else query_pct = 10;
         if ($urandom_range(0, 99) < query_pct) begin
            case ($urandom_range(0, 7))
               0: fraction = 17'd0;
               1: fraction = 17'd65536;
               2: fraction = 17'($urandom_range(65537, 131071));
               3: fraction = 17'd32768;
               default: fraction = 17'($urandom_range(0, 65536));
            endcase
            send_word(KIND_QUERY, $urandom, fraction);
         end else begin
            case ($urandom_range(0, 3))
               0: sample = $urandom_range(0, 15);
               1: sample = {1'b1, 31'($urandom)};
               default: sample = $urandom;
            endcase
            send_word(KIND_RECORD, sample, 17'($urandom));
         end
      end

      req_chan.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (64) @(negedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/swp_pkg.sv
rtl/core/swp_if.sv
rtl/core/swp_ram.sv
rtl/core/sliding_window_percentile_top.sv
rtl/core/swp_checker.sv
tb/swp_checker.sv
tb/sliding_window_percentile_top_tb.sv
